/* src/mfcs_pkg.sv */
// shared types, constants and helper functions of the music colour smoother
package mfcs_pkg;

   localparam logic [2:0] REG_LOW_BAND_TOP        = 3'd0;
   localparam logic [2:0] REG_MID_BAND_TOP        = 3'd1;
   localparam logic [2:0] REG_MAX_FREQUENCY       = 3'd2;
   localparam logic [2:0] REG_LOUDNESS_FULL_SCALE = 3'd3;
   localparam logic [2:0] REG_BRIGHT_ATTACK_COEF  = 3'd4;
   localparam logic [2:0] REG_BRIGHT_RELEASE_COEF = 3'd5;
   localparam logic [2:0] REG_COLOR_UP_COEF       = 3'd6;
   localparam logic [2:0] REG_COLOR_DOWN_COEF     = 3'd7;

   localparam logic [15:0] RST_LOW_BAND_TOP        = 16'd300;
   localparam logic [15:0] RST_MID_BAND_TOP        = 16'd2000;
   localparam logic [15:0] RST_MAX_FREQUENCY       = 16'd4000;
   localparam logic [15:0] RST_LOUDNESS_FULL_SCALE = 16'd4096;
   localparam logic [8:0]  RST_BRIGHT_ATTACK_COEF  = 9'd192;
   localparam logic [8:0]  RST_BRIGHT_RELEASE_COEF = 9'd230;
   localparam logic [8:0]  RST_COLOR_UP_COEF       = 9'd192;
   localparam logic [8:0]  RST_COLOR_DOWN_COEF     = 9'd230;

   localparam logic [8:0]  COEF_ONE    = 9'd256;
   localparam logic [16:0] SCALE_FLOOR = 17'd19661;
   localparam logic [15:0] SCALE_SPAN  = 16'd45875;
   localparam logic [16:0] RATIO_ONE   = 17'h10000;
   localparam logic [7:0]  POS_MAX     = 8'hFF;
   localparam logic [4:0]  POS_STEPS   = 5'd8;
   localparam logic [4:0]  RATIO_STEPS = 5'd16;

   typedef struct packed {
      logic [15:0] low_band_top;
      logic [15:0] mid_band_top;
      logic [15:0] max_frequency;
      logic [15:0] loudness_full_scale;
      logic [8:0]  bright_attack_coef;
      logic [8:0]  bright_release_coef;
      logic [8:0]  color_up_coef;
      logic [8:0]  color_down_coef;
   } cfg_type;

   typedef struct packed {
      logic load_in;
      logic prep;
      logic div_start;
      logic scale;
      logic target;
      logic filter;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic f_zero;
      logic div_done;
      logic out_free;
   } sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_START,
      ST_DIV,
      ST_SCALE,
      ST_TARGET,
      ST_FILTER,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      BAND_LOW,
      BAND_MID,
      BAND_HIGH
   } band_type;

   // element 0 red, 1 green, 2 blue
   typedef logic [2:0][7:0] rgb_type;

   function automatic rgb_type band_lo(band_type b);
      rgb_type v;
      v = '0;
      case (b)
         BAND_LOW: begin
            v[0] = 8'd64;
         end
         BAND_MID: begin
            v[1] = 8'd128;
         end
         BAND_HIGH: begin
            v[2] = 8'd128;
         end
         default: begin
            v = '0;
         end
      endcase
      return v;
   endfunction

   function automatic rgb_type band_hi(band_type b);
      rgb_type v;
      v = '0;
      case (b)
         BAND_LOW: begin
            v[0] = 8'd255;
            v[1] = 8'd165;
         end
         BAND_MID: begin
            v[0] = 8'd255;
            v[1] = 8'd255;
         end
         BAND_HIGH: begin
            v[0] = 8'd128;
            v[2] = 8'd128;
         end
         default: begin
            v = '0;
         end
      endcase
      return v;
   endfunction

   // q8 one-pole filter, weight clipped to one
   function automatic logic [7:0] blend_q8(logic [8:0] coef, logic [7:0] old,
                                           logic [7:0] tgt);
      logic [8:0]  c;
      logic [16:0] s;
      c = (coef > COEF_ONE) ? COEF_ONE : coef;
      s = 17'(c) * 17'(old) + 17'(COEF_ONE - c) * 17'(tgt);
      return s[15:8];
   endfunction

endpackage

/* src/music_freq_to_color_smoother.sv */
// top level: music frequency to smoothed grb colour, with register file and sequencer
// a response waits for the 16-step loudness ratio divider
// with zero frequency the colour path is skipped
// one transaction in flight at a time; the request input stays stalled until it is done
// a finished result waits in the output register while the next request is taken
// reset: synchronous, clears brightness, colour state and valid; registers take defaults
module music_freq_to_color_smoother
   import mfcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_frequency_hz,
   input  logic [15:0] req_loudness,
   input  logic [7:0]  req_target_brightness,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_led_word,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   mfcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mfcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mfcs_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_frequency_hz      (req_frequency_hz),
      .req_loudness          (req_loudness),
      .req_target_brightness (req_target_brightness),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_led_word          (rsp_led_word)
   );

   // an accepted transaction keeps the input stalled while it is worked on
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a transaction is still in flight");

   // scaling only runs once both dividers have finished
   assert property (@(posedge clock) disable iff (reset)
      cmd.scale |-> sts.div_done)
      else $error("scaling started with a divider still busy");

   // a new result never overwrites one that is still stalled
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("output register loaded over a pending result");

endmodule

/* src/mfcs_csr.sv */
// configuration register file behind the apb-style port
module mfcs_csr
   import mfcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] index;
   logic       wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_LOW_BAND_TOP:        cfg_in.low_band_top        = csr_pwdata[15:0];
            REG_MID_BAND_TOP:        cfg_in.mid_band_top        = csr_pwdata[15:0];
            REG_MAX_FREQUENCY:       cfg_in.max_frequency       = csr_pwdata[15:0];
            REG_LOUDNESS_FULL_SCALE: cfg_in.loudness_full_scale = csr_pwdata[15:0];
            REG_BRIGHT_ATTACK_COEF:  cfg_in.bright_attack_coef  = csr_pwdata[8:0];
            REG_BRIGHT_RELEASE_COEF: cfg_in.bright_release_coef = csr_pwdata[8:0];
            REG_COLOR_UP_COEF:       cfg_in.color_up_coef       = csr_pwdata[8:0];
            REG_COLOR_DOWN_COEF:     cfg_in.color_down_coef     = csr_pwdata[8:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_LOW_BAND_TOP:        csr_prdata = {16'h0, cfg_ff.low_band_top};
         REG_MID_BAND_TOP:        csr_prdata = {16'h0, cfg_ff.mid_band_top};
         REG_MAX_FREQUENCY:       csr_prdata = {16'h0, cfg_ff.max_frequency};
         REG_LOUDNESS_FULL_SCALE: csr_prdata = {16'h0, cfg_ff.loudness_full_scale};
         REG_BRIGHT_ATTACK_COEF:  csr_prdata = {23'h0, cfg_ff.bright_attack_coef};
         REG_BRIGHT_RELEASE_COEF: csr_prdata = {23'h0, cfg_ff.bright_release_coef};
         REG_COLOR_UP_COEF:       csr_prdata = {23'h0, cfg_ff.color_up_coef};
         REG_COLOR_DOWN_COEF:     csr_prdata = {23'h0, cfg_ff.color_down_coef};
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_band_top        <= RST_LOW_BAND_TOP;
         cfg_ff.mid_band_top        <= RST_MID_BAND_TOP;
         cfg_ff.max_frequency       <= RST_MAX_FREQUENCY;
         cfg_ff.loudness_full_scale <= RST_LOUDNESS_FULL_SCALE;
         cfg_ff.bright_attack_coef  <= RST_BRIGHT_ATTACK_COEF;
         cfg_ff.bright_release_coef <= RST_BRIGHT_RELEASE_COEF;
         cfg_ff.color_up_coef       <= RST_COLOR_UP_COEF;
         cfg_ff.color_down_coef     <= RST_COLOR_DOWN_COEF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/mfcs_div.sv */
// restoring divider, one quotient bit per cycle, remainder must start below the divisor
module mfcs_div
   import mfcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] rem_init,
   input  logic [15:0] bits_init,
   input  logic [15:0] divisor,
   input  logic [4:0]  steps,
   output logic        busy,
   output logic [15:0] quotient
);

   logic [15:0] rem_ff, rem_in;
   logic [15:0] bits_ff, bits_in;
   logic [15:0] den_ff, den_in;
   logic [15:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [16:0] trial;
   logic        fits;

   assign trial    = {rem_ff, bits_ff[15]};
   assign fits     = trial >= {1'b0, den_ff};
   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      bits_in = bits_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         rem_in  = rem_init;
         bits_in = bits_init;
         den_in  = divisor;
         quo_in  = '0;
         cnt_in  = steps;
      end else if (busy) begin
         rem_in  = fits ? 16'(trial - {1'b0, den_ff}) : trial[15:0];
         bits_in = {bits_ff[14:0], 1'b0};
         quo_in  = {quo_ff[14:0], fits};
         cnt_in  = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

endmodule

/* src/mfcs_ctrl.sv */
// sequencer that steps one transaction through the datapath
module mfcs_ctrl
   import mfcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   assign req_stall = state_ff != ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = sts.f_zero ? ST_OUTPUT : ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_TARGET;
         end
         ST_TARGET: begin
            cmd.target = 1'b1;
            state_in   = ST_FILTER;
         end
         ST_FILTER: begin
            cmd.filter = 1'b1;
            state_in   = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* src/mfcs_dp.sv */
// datapath: band mapping, dividers, colour scaling, smoothing filters and output register
module mfcs_dp
   import mfcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [15:0] req_frequency_hz,
   input  logic [15:0] req_loudness,
   input  logic [7:0]  req_target_brightness,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_led_word
);

   logic [15:0] freq_ff, freq_in;
   logic [15:0] loud_ff, loud_in;
   logic [7:0]  tb_ff, tb_in;
   logic [7:0]  bright_ff, bright_in;
   band_type    band_ff, band_in;
   logic [15:0] x_ff, x_in;
   logic [15:0] den_ff, den_in;
   logic        room_sat_ff, room_sat_in;
   logic        ratio_sat_ff, ratio_sat_in;
   logic        pos_sat_ff, pos_sat_in;
   logic [16:0] scale_ff, scale_in;
   rgb_type     base_ff, base_in;
   rgb_type     tgt_ff, tgt_in;
   rgb_type     smooth_ff, smooth_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] led_ff, led_in;

   logic [23:0] num;
   logic        over;
   logic        pos_busy, ratio_busy;
   logic [15:0] pos_q, ratio_q;
   logic [16:0] ratio;
   logic [32:0] scale_prod;
   logic [7:0]  pos;
   rgb_type     lo, hi;
   logic [15:0] base_prod [3];
   logic [24:0] tgt_prod [3];
   logic [15:0] out_prod [3];
   logic [8:0]  bright_coef;
   logic [8:0]  color_coef [3];

   assign num  = {x_ff, 8'h00} - {8'h00, x_ff};
   assign over = num >= {den_ff, 8'h00};

   mfcs_div u_pos_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .rem_init  (num[23:8]),
      .bits_init ({num[7:0], 8'h00}),
      .divisor   (den_ff),
      .steps     (POS_STEPS),
      .busy      (pos_busy),
      .quotient  (pos_q)
   );

   mfcs_div u_ratio_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .rem_init  (loud_ff),
      .bits_init (16'h0000),
      .divisor   (cfg.loudness_full_scale),
      .steps     (RATIO_STEPS),
      .busy      (ratio_busy),
      .quotient  (ratio_q)
   );

   assign sts.f_zero   = freq_ff == '0;
   assign sts.div_done = !pos_busy && !ratio_busy;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_led_word = led_ff;

   assign ratio       = ratio_sat_ff ? RATIO_ONE : {1'b0, ratio_q};
   assign scale_prod  = 33'(ratio) * 33'(SCALE_SPAN);
   assign pos         = pos_sat_ff ? POS_MAX : pos_q[7:0];
   assign lo          = band_lo(band_ff);
   assign hi          = band_hi(band_ff);
   assign bright_coef = (tb_ff > bright_ff) ? cfg.bright_attack_coef
                                            : cfg.bright_release_coef;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         base_prod[k]  = 16'(hi[k] - lo[k]) * 16'(pos);
         tgt_prod[k]   = 25'(base_ff[k]) * 25'(scale_ff);
         out_prod[k]   = 16'(smooth_ff[k]) * 16'(bright_ff);
         color_coef[k] = (tgt_ff[k] >= smooth_ff[k]) ? cfg.color_up_coef
                                                     : cfg.color_down_coef;
      end
   end

   always_comb begin
      freq_in      = freq_ff;
      loud_in      = loud_ff;
      tb_in        = tb_ff;
      bright_in    = bright_ff;
      band_in      = band_ff;
      x_in         = x_ff;
      den_in       = den_ff;
      room_sat_in  = room_sat_ff;
      ratio_sat_in = ratio_sat_ff;
      pos_sat_in   = pos_sat_ff;
      scale_in     = scale_ff;
      base_in      = base_ff;
      tgt_in       = tgt_ff;
      smooth_in    = smooth_ff;
      rsp_valid_in = rsp_valid_ff;
      led_in       = led_ff;

      if (cmd.load_in) begin
         freq_in = req_frequency_hz;
         loud_in = req_loudness;
         tb_in   = req_target_brightness;
      end

      if (cmd.prep) begin
         bright_in = blend_q8(bright_coef, bright_ff, tb_ff);
         if (freq_ff <= cfg.low_band_top) begin
            band_in     = BAND_LOW;
            x_in        = freq_ff;
            den_in      = cfg.low_band_top;
            room_sat_in = 1'b0;
         end else if (freq_ff <= cfg.mid_band_top) begin
            band_in     = BAND_MID;
            x_in        = freq_ff - cfg.low_band_top;
            den_in      = cfg.mid_band_top - cfg.low_band_top;
            room_sat_in = 1'b0;
         end else begin
            band_in     = BAND_HIGH;
            x_in        = freq_ff - cfg.mid_band_top;
            den_in      = cfg.max_frequency - cfg.mid_band_top;
            room_sat_in = cfg.max_frequency <= cfg.mid_band_top;
         end
         ratio_sat_in = (cfg.loudness_full_scale == '0) ||
                        (loud_ff >= cfg.loudness_full_scale);
      end

      if (cmd.div_start) begin
         pos_sat_in = room_sat_ff || over;
      end

      if (cmd.scale) begin
         scale_in = SCALE_FLOOR + scale_prod[32:16];
         for (int k = 0; k < 3; k++) begin
            base_in[k] = lo[k] + base_prod[k][15:8];
         end
      end

      if (cmd.target) begin
         for (int k = 0; k < 3; k++) begin
            tgt_in[k] = tgt_prod[k][23:16];
         end
      end

      if (cmd.filter) begin
         for (int k = 0; k < 3; k++) begin
            smooth_in[k] = blend_q8(color_coef[k], smooth_ff[k], tgt_ff[k]);
         end
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         led_in       = {out_prod[1][15:8], out_prod[0][15:8], out_prod[2][15:8]};
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff    <= '0;
         smooth_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bright_ff    <= bright_in;
         smooth_ff    <= smooth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      freq_ff      <= freq_in;
      loud_ff      <= loud_in;
      tb_ff        <= tb_in;
      band_ff      <= band_in;
      x_ff         <= x_in;
      den_ff       <= den_in;
      room_sat_ff  <= room_sat_in;
      ratio_sat_ff <= ratio_sat_in;
      pos_sat_ff   <= pos_sat_in;
      scale_ff     <= scale_in;
      base_ff      <= base_in;
      tgt_ff       <= tgt_in;
      led_ff       <= led_in;
   end

endmodule
